[hdl/fsp_pkg.sv]
// Shared types, codes and a helper function for the framebuffer scan-out palette unit.
package fsp_pkg;

    // Palette geometry.
    localparam int unsigned PAL_ENTRIES = 256;
    localparam int unsigned PAL_AW      = $clog2(PAL_ENTRIES);

    // Depth of the queue between the front and the back part.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Configuration port address width (seven registers at 4-byte spacing).
    localparam int unsigned APB_AW = 5;

    // Placement biases and the opaque alpha byte.
    localparam logic [31:0] X_BIAS       = 32'd96;
    localparam logic [31:0] Y_BIAS       = 32'd8;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // Request modes.
    typedef enum logic [1:0] {
        MODE_SET_INDEX = 2'd0,
        MODE_WRITE_PAL = 2'd1,
        MODE_PIXEL     = 2'd2
    } t_mode;

    // Pixel formats that draw; the other codes draw nothing.
    typedef enum logic [1:0] {
        FMT_INDEXED = 2'd0,
        FMT_RGB555  = 2'd2
    } t_fmt;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_X_OFFSET     = 3'd0,
        REG_SRC_WIDTH    = 3'd1,
        REG_Y_OFFSET     = 3'd2,
        REG_SRC_HEIGHT   = 3'd3,
        REG_LINE_STRIDE  = 3'd4,
        REG_BASE_ADDRESS = 3'd5,
        REG_PIXEL_FORMAT = 3'd6
    } t_reg_idx;

    // Operation that the back part carries out for one request.
    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_PAL_WR  = 2'd1,
        OP_PIX_IDX = 2'd2,
        OP_PIX_RGB = 2'd3
    } t_op;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [31:0] x_offset;
        logic [31:0] src_width;
        logic [31:0] y_offset;
        logic [31:0] src_height;
        logic [31:0] line_stride;
        logic [31:0] base_address;
        logic [1:0]  pixel_format;
    } t_cfg;

    // One classified request in the queue.
    typedef struct packed {
        t_op         op;
        logic [7:0]  pal_addr;
        logic [31:0] pal_data;
        logic [9:0]  x;
        logic [8:0]  y;
        logic [15:0] pix;
        logic [9:0]  dx;
        logic [8:0]  dy;
        logic        draw;
    } t_qent;

    // One result.
    typedef struct packed {
        logic [31:0] fetch_address;
        logic [9:0]  dest_x;
        logic [8:0]  dest_y;
        logic [31:0] color;
        logic        draw_valid;
    } t_res;

    // Expand a 5-bit channel to 8 bits as c*255/31, rounded down. The divide by 31 is a
    // multiply by 33826/2^20, which gives the exact quotient for every 5-bit input.
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [12:0] prod;
        logic [28:0] scaled;
        prod   = 13'(c) * 13'd255;
        scaled = 29'(prod) * 29'd33826;
        return scaled[27:20];
    endfunction

endpackage

[hdl/fsp_if.sv]
// Request and result channel interfaces of the scan-out palette unit.
interface fsp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] write_data;
    logic [31:0] write_mask;
    logic [9:0]  src_x;
    logic [8:0]  src_y;
    logic [15:0] pixel_value;

    modport source(output valid, mode, write_data, write_mask, src_x, src_y, pixel_value,
                   input ready);
    modport sink(input valid, mode, write_data, write_mask, src_x, src_y, pixel_value,
                 output ready);
endinterface

interface fsp_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] fetch_address;
    logic [9:0]  dest_x;
    logic [8:0]  dest_y;
    logic [31:0] color;
    logic        draw_valid;

    modport source(output valid, fetch_address, dest_x, dest_y, color, draw_valid,
                   input ready);
    modport sink(input valid, fetch_address, dest_x, dest_y, color, draw_valid,
                 output ready);
endinterface

[hdl/fsp_front.sv]
// Front part: accepts requests, keeps the palette index and classifies each request.
module fsp_front #(
    parameter int unsigned DISPLAY_WIDTH  = 854,
    parameter int unsigned DISPLAY_HEIGHT = 480
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsp_req_if.sink       i_req,
    input  fsp_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output fsp_pkg::t_qent o_push_data
);
    import fsp_pkg::*;

    logic [7:0]  r_pal_idx;
    logic [7:0]  n_pal_idx;
    logic [31:0] w_masked;
    logic [31:0] w_dx;
    logic [31:0] w_dy;
    logic        w_in_src;
    logic        w_in_disp;

    // A request is taken whenever the queue has room.
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // Placement, clipping and operation decode.
    always_comb begin
        w_masked  = i_req.write_data & i_req.write_mask;
        w_dx      = 32'(i_req.src_x) + i_cfg.x_offset - X_BIAS;
        w_dy      = 32'(i_req.src_y) + i_cfg.y_offset - Y_BIAS;
        w_in_src  = (32'(i_req.src_x) < i_cfg.src_width)
                 && (32'(i_req.src_x) < 32'(DISPLAY_WIDTH))
                 && (32'(i_req.src_y) < i_cfg.src_height)
                 && (32'(i_req.src_y) < 32'(DISPLAY_HEIGHT));
        w_in_disp = (w_dx < 32'(DISPLAY_WIDTH)) && (w_dy < 32'(DISPLAY_HEIGHT));

        o_push_data.pal_addr = r_pal_idx;
        o_push_data.pal_data = {ALPHA_OPAQUE, w_masked[7:0], w_masked[15:8], w_masked[23:16]};
        o_push_data.x        = i_req.src_x;
        o_push_data.y        = i_req.src_y;
        o_push_data.pix      = i_req.pixel_value;
        o_push_data.dx       = w_dx[9:0];
        o_push_data.dy       = w_dy[8:0];
        o_push_data.draw     = w_in_src && w_in_disp;

        n_pal_idx = r_pal_idx;
        case (t_mode'(i_req.mode))
            MODE_SET_INDEX: begin
                o_push_data.op = OP_NONE;
                n_pal_idx = (r_pal_idx & ~i_req.write_mask[7:0])
                          | (i_req.write_data[7:0] & i_req.write_mask[7:0]);
            end
            MODE_WRITE_PAL: begin
                o_push_data.op = OP_PAL_WR;
                n_pal_idx = r_pal_idx + 8'd1;
            end
            MODE_PIXEL: begin
                case (t_fmt'(i_cfg.pixel_format))
                    FMT_INDEXED: o_push_data.op = OP_PIX_IDX;
                    FMT_RGB555:  o_push_data.op = OP_PIX_RGB;
                    default:     o_push_data.op = OP_NONE;
                endcase
            end
            default: begin
                o_push_data.op = OP_NONE;
            end
        endcase
    end

    // Palette index register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_idx <= '0;
        end else if (o_push) begin
            r_pal_idx <= n_pal_idx;
        end
    end

endmodule

[hdl/fsp_queue.sv]
// Short queue between the front and the back part.
module fsp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fsp_pkg::t_qent i_push_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_head_vld,
    output fsp_pkg::t_qent o_head
);
    import fsp_pkg::*;

    t_qent               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_cnt;

    assign o_full     = (r_cnt == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_head_vld = (r_cnt != '0);
    assign o_head     = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hdl/fsp_back.sv]
// Back part: palette memory, colour expansion, fetch address and the result register.
module fsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fsp_pkg::t_cfg  i_cfg,
    input  logic           i_head_vld,
    input  fsp_pkg::t_qent i_head,
    output logic           o_pop,
    fsp_res_if.source      o_res
);
    import fsp_pkg::*;

    logic [31:0]            r_pal_mem [PAL_ENTRIES];
    logic [PAL_ENTRIES-1:0] r_pal_ok;
    logic [31:0]            r_rd_data;
    logic                   r_rd_ok;

    logic        r_s1_vld;
    t_op         r_s1_op;
    logic        r_s1_draw;
    logic [9:0]  r_s1_dx;
    logic [8:0]  r_s1_dy;
    logic [9:0]  r_s1_x;
    logic [31:0] r_s1_prod;
    logic [31:0] r_s1_rgb;

    logic        r_out_vld;
    t_res        r_out;
    t_res        n_out;

    logic        w_en;
    logic        w_pal_wr;
    logic [31:0] w_pos;
    logic [31:0] w_addr;
    logic [31:0] w_color;

    // The pipeline moves whenever the result register is free or being taken.
    assign w_en     = !r_out_vld || o_res.ready;
    assign o_pop    = w_en && i_head_vld;
    assign w_pal_wr = o_pop && (i_head.op == OP_PAL_WR);

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_pal_wr) begin
            r_pal_mem[i_head.pal_addr] <= i_head.pal_data;
        end
        if (w_en) begin
            r_rd_data <= r_pal_mem[i_head.pix[PAL_AW-1:0]];
            r_rd_ok   <= r_pal_ok[i_head.pix[PAL_AW-1:0]];
        end
    end

    // Per-entry written flags; an unwritten entry reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_ok <= '0;
        end else if (w_pal_wr) begin
            r_pal_ok[i_head.pal_addr] <= 1'b1;
        end
    end

    // Stage one: line offset product and RGB555 expansion.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_head_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op   <= i_head.op;
            r_s1_draw <= i_head.draw;
            r_s1_dx   <= i_head.dx;
            r_s1_dy   <= i_head.dy;
            r_s1_x    <= i_head.x;
            r_s1_prod <= i_cfg.line_stride * 32'(i_head.y);
            r_s1_rgb  <= {ALPHA_OPAQUE, expand5(i_head.pix[4:0]),
                          expand5(i_head.pix[9:5]), expand5(i_head.pix[14:10])};
        end
    end

    // Stage two: fetch address, colour choice and result assembly.
    always_comb begin
        w_pos   = r_s1_prod + 32'(r_s1_x);
        w_addr  = i_cfg.base_address
                + ((r_s1_op == OP_PIX_RGB) ? {w_pos[30:0], 1'b0} : w_pos);
        w_color = (r_s1_op == OP_PIX_RGB) ? r_s1_rgb : (r_rd_ok ? r_rd_data : '0);

        n_out = '0;
        if ((r_s1_op == OP_PIX_IDX) || (r_s1_op == OP_PIX_RGB)) begin
            n_out.fetch_address = w_addr;
            if (r_s1_draw) begin
                n_out.dest_x     = r_s1_dx;
                n_out.dest_y     = r_s1_dy;
                n_out.color      = w_color;
                n_out.draw_valid = 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.fetch_address = r_out.fetch_address;
    assign o_res.dest_x        = r_out.dest_x;
    assign o_res.dest_y        = r_out.dest_y;
    assign o_res.color         = r_out.color;
    assign o_res.draw_valid    = r_out.draw_valid;

endmodule

[hdl/framebuffer_scanout_palette_unit.sv]
// Top level of the framebuffer scan-out palette unit with its configuration registers.
//
// Requests arrive on i_req (valid/ready). Mode 0 loads the palette index under a mask,
// mode 1 writes one palette entry and advances the index, mode 2 scans out one pixel.
// Every request gives exactly one result on o_res (valid/ready), in request order.
// A request is accepted every cycle while the four-entry request queue has room.
// With the receiver ready, a taken request is written into the queue, then into the
// stage-one registers with the palette read and line-offset multiply; the address
// add then feeds the result register. Throughput is one request per cycle while the
// receiver is ready, set by the pipeline, which moves one request per stage per cycle;
// the palette has one write port and one registered read port.
// When the receiver stalls, the result register holds, the back part stops and the
// queue fills; i_req.ready falls once the queue is full.
// Configuration is written over the APB-style port, one register per 4 bytes, and
// should only change while the unit is idle. pready is always high.
// Synchronous reset clears the registers, the palette index, the queue, the pipeline
// and the palette written flags at once, so every palette entry reads as zero after
// reset with no clearing pass.
module framebuffer_scanout_palette_unit #(
    parameter int unsigned DISPLAY_WIDTH  = 854,
    parameter int unsigned DISPLAY_HEIGHT = 480
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    fsp_req_if.sink                    i_req,
    fsp_res_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fsp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import fsp_pkg::*;

    t_cfg     r_cfg;
    logic     w_wr;
    t_reg_idx w_reg;
    logic     w_full;
    logic     w_push;
    t_qent    w_push_data;
    logic     w_pop;
    logic     w_head_vld;
    t_qent    w_head;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_reg  = t_reg_idx'(paddr[APB_AW-1:2]);

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_X_OFFSET:     r_cfg.x_offset     <= pwdata;
                REG_SRC_WIDTH:    r_cfg.src_width    <= pwdata;
                REG_Y_OFFSET:     r_cfg.y_offset     <= pwdata;
                REG_SRC_HEIGHT:   r_cfg.src_height   <= pwdata;
                REG_LINE_STRIDE:  r_cfg.line_stride  <= pwdata;
                REG_BASE_ADDRESS: r_cfg.base_address <= pwdata;
                REG_PIXEL_FORMAT: r_cfg.pixel_format <= pwdata[1:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Configuration register reads.
    always_comb begin
        case (w_reg)
            REG_X_OFFSET:     prdata = r_cfg.x_offset;
            REG_SRC_WIDTH:    prdata = r_cfg.src_width;
            REG_Y_OFFSET:     prdata = r_cfg.y_offset;
            REG_SRC_HEIGHT:   prdata = r_cfg.src_height;
            REG_LINE_STRIDE:  prdata = r_cfg.line_stride;
            REG_BASE_ADDRESS: prdata = r_cfg.base_address;
            REG_PIXEL_FORMAT: prdata = 32'(r_cfg.pixel_format);
            default:          prdata = '0;
        endcase
    end

    fsp_front #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (r_cfg),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    fsp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_head_vld  (w_head_vld),
        .o_head      (w_head)
    );

    fsp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head_vld (w_head_vld),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_res      (o_res)
    );

endmodule

[hdl/fsp_checker.sv]
// Port-level checks on the result channel of the scan-out palette unit, with its bind.
module fsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_draw_valid,
    input logic [9:0]  i_dest_x,
    input logic [8:0]  i_dest_y,
    input logic [31:0] i_color
);

    // A stalled result stays on offer with the same colour.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_color))
        else $error("result dropped or changed while stalled");

    // A pixel that is not drawn carries no position and no colour.
    a_undrawn_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_draw_valid |-> i_dest_x == '0 && i_dest_y == '0 && i_color == '0)
        else $error("undrawn result has non-zero position or colour");

    // Reset leaves no result on offer.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind framebuffer_scanout_palette_unit fsp_checker u_fsp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_draw_valid (o_res.draw_valid),
    .i_dest_x     (o_res.dest_x),
    .i_dest_y     (o_res.dest_y),
    .i_color      (o_res.color)
);

[dv/tb_framebuffer_scanout_palette_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the framebuffer scan-out palette unit with its own scan-out predictor.
module tb_framebuffer_scanout_palette_unit;
    import fsp_pkg::*;

    localparam int unsigned DISP_W = 854;
    localparam int unsigned DISP_H = 480;

    // Format codes that draw nothing, and a register slot past the end of the map.
    localparam logic [1:0] FMT_BLANK_A = 2'd1;
    localparam logic [1:0] FMT_BLANK_B = 2'd3;
    localparam logic [2:0] REG_SPARE   = 3'd7;

    localparam int QUIET_LIMIT   = 2000;
    localparam int STALL_AFTER   = 400;
    localparam int STALL_CYCLES  = 64;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_REQS    = 150;

    typedef struct {
        t_mode       mode;
        logic [31:0] wdata;
        logic [31:0] wmask;
        logic [9:0]  x;
        logic [8:0]  y;
        logic [15:0] pix;
    } scan_req_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [31:0]           pwdata;
    wire  [31:0]           prdata;
    wire                   pready;

    fsp_req_if req_ch();
    fsp_res_if res_ch();

    framebuffer_scanout_palette_unit #(
        .DISPLAY_WIDTH  (DISP_W),
        .DISPLAY_HEIGHT (DISP_H)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the palette, the index and the registers.
    logic [31:0] pal_shadow [PAL_ENTRIES];
    logic [7:0]  pal_ptr;
    logic [31:0] cfg_x_off;
    logic [31:0] cfg_width;
    logic [31:0] cfg_y_off;
    logic [31:0] cfg_height;
    logic [31:0] cfg_stride;
    logic [31:0] cfg_base;
    logic [1:0]  cfg_fmt;

    scan_req_t pending_reqs[$];
    t_res      expected_results[$];
    scan_req_t cur_req;
    t_res      want_res;

    bit idle_on;
    bit offer_live;
    bit long_stall_done;
    int src_gap;
    int snk_hold;
    int results_seen;
    int mismatch_count;
    int quiet_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Widen a 5-bit colour channel to 8 bits, rounding down.
    function automatic logic [7:0] chan5to8(input logic [4:0] c);
        int unsigned p;
        p = 32'(c) * 32'd255;
        return 8'(p / 32'd31);
    endfunction

    // Work out the result of one request and update the palette state.
    function automatic t_res scanout_predict(input scan_req_t rq);
        t_res        r;
        logic [31:0] masked;
        logic [31:0] w_clip;
        logic [31:0] h_clip;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] pos;
        logic [31:0] addr;
        logic [31:0] colour;
        logic        draw;
        r = '0;
        case (rq.mode)
            MODE_SET_INDEX: begin
                pal_ptr = (pal_ptr & ~rq.wmask[7:0]) | (rq.wdata[7:0] & rq.wmask[7:0]);
            end
            MODE_WRITE_PAL: begin
                masked = rq.wdata & rq.wmask;
                pal_shadow[pal_ptr] = {ALPHA_OPAQUE, masked[7:0], masked[15:8], masked[23:16]};
                pal_ptr = pal_ptr + 8'd1;
            end
            MODE_PIXEL: begin
                if (cfg_fmt == FMT_INDEXED || cfg_fmt == FMT_RGB555) begin
                    w_clip = (cfg_width < DISP_W) ? cfg_width : DISP_W;
                    h_clip = (cfg_height < DISP_H) ? cfg_height : DISP_H;
                    dx = 32'(rq.x) + cfg_x_off - X_BIAS;
                    dy = 32'(rq.y) + cfg_y_off - Y_BIAS;
                    pos = 32'(rq.y) * cfg_stride + 32'(rq.x);
                    if (cfg_fmt == FMT_INDEXED) begin
                        addr = cfg_base + pos;
                        colour = pal_shadow[rq.pix[7:0]];
                    end else begin
                        addr = cfg_base + (pos << 1);
                        colour = {ALPHA_OPAQUE, chan5to8(rq.pix[4:0]), chan5to8(rq.pix[9:5]),
                                  chan5to8(rq.pix[14:10])};
                    end
                    draw = (32'(rq.x) < w_clip) && (32'(rq.y) < h_clip) &&
                           (dx < DISP_W) && (dy < DISP_H);
                    r.fetch_address = addr;
                    if (draw) begin
                        r.dest_x     = dx[9:0];
                        r.dest_y     = dy[8:0];
                        r.color      = colour;
                        r.draw_valid = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // One mismatch: print a line and count it.
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] result %0d: %s is 0x%08h, expected 0x%08h",
                 $time, results_seen, field, got, want);
    endtask

    // One register write: setup cycle, then access cycle.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] wr_value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wr_value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_X_OFFSET:     cfg_x_off  = wr_value;
            REG_SRC_WIDTH:    cfg_width  = wr_value;
            REG_Y_OFFSET:     cfg_y_off  = wr_value;
            REG_SRC_HEIGHT:   cfg_height = wr_value;
            REG_LINE_STRIDE:  cfg_stride = wr_value;
            REG_BASE_ADDRESS: cfg_base   = wr_value;
            REG_PIXEL_FORMAT: cfg_fmt    = wr_value[1:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic [31:0] x_off, input logic [31:0] width,
                              input logic [31:0] y_off, input logic [31:0] height,
                              input logic [31:0] stride, input logic [31:0] base,
                              input logic [31:0] fmt);
        cfg_write(REG_X_OFFSET, x_off);
        cfg_write(REG_SRC_WIDTH, width);
        cfg_write(REG_Y_OFFSET, y_off);
        cfg_write(REG_SRC_HEIGHT, height);
        cfg_write(REG_LINE_STRIDE, stride);
        cfg_write(REG_BASE_ADDRESS, base);
        cfg_write(REG_PIXEL_FORMAT, fmt);
    endtask

    task automatic push_pixel(input logic [9:0] x, input logic [8:0] y, input logic [15:0] pix);
        scan_req_t rq;
        rq.mode  = MODE_PIXEL;
        rq.wdata = $urandom;
        rq.wmask = $urandom;
        rq.x     = x;
        rq.y     = y;
        rq.pix   = pix;
        pending_reqs.push_back(rq);
    endtask

    task automatic push_reg(input t_mode m, input logic [31:0] d, input logic [31:0] mk);
        scan_req_t rq;
        rq.mode  = m;
        rq.wdata = d;
        rq.wmask = mk;
        rq.x     = 10'($urandom_range(0, DISP_W - 1));
        rq.y     = 9'($urandom_range(0, DISP_H - 1));
        rq.pix   = 16'($urandom);
        pending_reqs.push_back(rq);
    endtask

    // Wait until every request has gone in and every result has come out.
    task automatic drain;
        while (pending_reqs.size() != 0 || offer_live || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random placement offset: mostly near the bias, sometimes at the extremes.
    function automatic logic [31:0] pick_offset(input logic [31:0] bias);
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return bias + $urandom_range(0, 64) - 32'd32;
        endcase
    endfunction

    // Random source extent: mostly a plausible size, sometimes extreme.
    function automatic logic [31:0] pick_extent;
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(1, 900);
        endcase
    endfunction

    // Request driver: offers queued requests, with random idle bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            offer_live = 1'b0;
            src_gap = 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(scanout_predict(cur_req));
                offer_live = 1'b0;
            end
            if (!offer_live) begin
                if (src_gap > 0) begin
                    src_gap--;
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() != 0 && idle_on &&
                             $urandom_range(0, 99) < 6) begin
                    src_gap = $urandom_range(0, 11);
                    req_ch.valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_ch.mode        <= cur_req.mode;
                    req_ch.write_data  <= cur_req.wdata;
                    req_ch.write_mask  <= cur_req.wmask;
                    req_ch.src_x       <= cur_req.x;
                    req_ch.src_y       <= cur_req.y;
                    req_ch.pixel_value <= cur_req.pix;
                    req_ch.valid       <= 1'b1;
                    offer_live = 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each result and throttles ready, with one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            snk_hold = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, fetch_address", res_ch.fetch_address, '0);
                end else begin
                    want_res = expected_results.pop_front();
                    if (res_ch.fetch_address !== want_res.fetch_address)
                        report_mismatch("fetch_address", res_ch.fetch_address,
                                        want_res.fetch_address);
                    if (res_ch.dest_x !== want_res.dest_x)
                        report_mismatch("dest_x", 32'(res_ch.dest_x), 32'(want_res.dest_x));
                    if (res_ch.dest_y !== want_res.dest_y)
                        report_mismatch("dest_y", 32'(res_ch.dest_y), 32'(want_res.dest_y));
                    if (res_ch.color !== want_res.color)
                        report_mismatch("color", res_ch.color, want_res.color);
                    if (res_ch.draw_valid !== want_res.draw_valid)
                        report_mismatch("draw_valid", 32'(res_ch.draw_valid),
                                        32'(want_res.draw_valid));
                end
            end
            if (snk_hold > 0) begin
                snk_hold--;
                res_ch.ready <= 1'b0;
            end else if (!long_stall_done && results_seen >= STALL_AFTER &&
                         pending_reqs.size() > 20) begin
                long_stall_done = 1'b1;
                snk_hold = STALL_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 6) begin
                snk_hold = $urandom_range(0, 11);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || psel || (req_ch.valid && req_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL framebuffer_scanout_palette_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus sequence.
    initial begin
        int unsigned n;
        int unsigned k;
        int unsigned burst;
        logic [31:0] fmt;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        req_ch.valid       = 1'b0;
        req_ch.mode        = '0;
        req_ch.write_data  = '0;
        req_ch.write_mask  = '0;
        req_ch.src_x       = '0;
        req_ch.src_y       = '0;
        req_ch.pixel_value = '0;
        res_ch.ready       = 1'b0;
        foreach (pal_shadow[i]) pal_shadow[i] = '0;
        pal_ptr    = '0;
        cfg_x_off  = '0;
        cfg_width  = '0;
        cfg_y_off  = '0;
        cfg_height = '0;
        cfg_stride = '0;
        cfg_base   = '0;
        cfg_fmt    = '0;
        idle_on         = 1'b1;
        long_stall_done = 1'b0;
        results_seen    = 0;
        mismatch_count  = 0;
        quiet_cycles    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at reset: zero width, so the pixel is fetched but not drawn.
        push_pixel(10'd5, 9'd3, 16'h00FF);
        drain;

        // Indexed format, identity placement; a write past the register map is ignored.
        set_config(X_BIAS, DISP_W, Y_BIAS, DISP_H, DISP_W, 32'h1000_0000, FMT_INDEXED);
        cfg_write(REG_SPARE, 32'hFFFF_FFFF);
        push_pixel(10'd0, 9'd0, 16'h0000);
        push_reg(MODE_SET_INDEX, 32'hFFFF_FFFF, 32'h0000_0000);
        push_reg(MODE_SET_INDEX, 32'h0000_00FF, 32'hFFFF_FFFF);
        push_reg(MODE_WRITE_PAL, 32'h0012_3456, 32'hFFFF_FFFF);
        push_reg(MODE_WRITE_PAL, 32'hFFFF_FFFF, 32'h00FF_00FF);
        push_pixel(10'd853, 9'd479, 16'hFFFF);
        push_pixel(10'd0, 9'd0, 16'h0100);
        push_reg(MODE_SET_INDEX, 32'h0000_0000, 32'h0000_0000);
        push_pixel(10'd853, 9'd0, 16'h0001);
        drain;

        // RGB555 selected by an over-wide value; width clip and offset wrap.
        set_config(32'h0, 32'd100, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFE);
        push_pixel(10'd95, 9'd8, 16'h7FFF);
        push_pixel(10'd96, 9'd8, 16'h8000);
        push_pixel(10'd99, 9'd479, 16'hFFFF);
        push_pixel(10'd100, 9'd479, 16'hFFFF);
        push_pixel(10'd96, 9'd7, 16'h0421);
        drain;

        // Formats that draw nothing, then the largest horizontal offset.
        cfg_write(REG_PIXEL_FORMAT, 32'(FMT_BLANK_A));
        push_pixel(10'd200, 9'd100, 16'h1234);
        drain;
        cfg_write(REG_PIXEL_FORMAT, 32'(FMT_BLANK_B));
        push_pixel(10'd300, 9'd200, 16'hABCD);
        drain;
        cfg_write(REG_X_OFFSET, 32'hFFFF_FFFF);
        cfg_write(REG_PIXEL_FORMAT, 32'(FMT_INDEXED));
        push_pixel(10'd97, 9'd20, 16'h00FF);
        push_pixel(10'd96, 9'd20, 16'h00FF);
        drain;

        // Random phases, each with its own settings; no idling in the last one.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain;
            idle_on = (p != RANDOM_PHASES - 1);
            if (p == 2) fmt = 32'(FMT_BLANK_A);
            else if (p == 5) fmt = 32'(FMT_BLANK_B);
            else if (p % 2 == 1) fmt = 32'(FMT_RGB555);
            else fmt = 32'(FMT_INDEXED);
            set_config(pick_offset(X_BIAS), pick_extent(), pick_offset(Y_BIAS), pick_extent(),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1024),
                       $urandom, fmt);
            n = 0;
            while (n < PHASE_REQS) begin
                k = $urandom_range(0, 99);
                if (k < 8) begin
                    // Palette load: set the index, then a run of entries.
                    push_reg(MODE_SET_INDEX, $urandom, (k < 2) ? $urandom : 32'h0000_00FF);
                    burst = $urandom_range(1, 8);
                    repeat (burst) begin
                        push_reg(MODE_WRITE_PAL, $urandom,
                                 ($urandom_range(0, 3) == 0) ? $urandom : 32'h00FF_FFFF);
                    end
                    n += burst + 1;
                end else if (k < 14) begin
                    push_reg(MODE_WRITE_PAL, $urandom, $urandom);
                    n++;
                end else if (k < 17) begin
                    push_reg(MODE_SET_INDEX, $urandom, $urandom);
                    n++;
                end else begin
                    push_pixel(10'($urandom_range(0, DISP_W - 1)),
                               9'($urandom_range(0, DISP_H - 1)), 16'($urandom));
                    n++;
                end
            end
        end

        drain;
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS framebuffer_scanout_palette_unit");
        end else begin
            $display("FAIL framebuffer_scanout_palette_unit");
        end
        $finish;
    end

endmodule
